// ===== rtl/core/afc_pkg.sv =====
// afc_pkg: shared constants and result type of the addressed frame checker
// no dependencies; imported by addressed_frame_checker_top and its testbench
package afc_pkg;

    localparam logic [7:0] MAX_FRAME_BYTES = 8'd253;
    localparam logic [7:0] MIN_FRAME_BYTES = 8'd6;
    localparam logic [7:0] START_BYTE      = 8'hAA;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [QCNT_W-1:0] QUEUE_FULL_LEVEL = 3'd4;
    localparam logic [QCNT_W-1:0] QUEUE_PUSH_LEVEL = 3'd2;

    localparam int unsigned PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_LOCAL_ADDRESS = 2'd0;

    localparam logic [2:0] VERDICT_ACCEPTED     = 3'd0;
    localparam logic [2:0] VERDICT_TOO_SHORT    = 3'd1;
    localparam logic [2:0] VERDICT_BAD_START    = 3'd2;
    localparam logic [2:0] VERDICT_ADDR_MISMATCH = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd4;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        end_of_frame;
        logic [2:0]  verdict;
        logic [15:0] source_address;
        logic [7:0]  frame_length;
    } afc_result_t;

endpackage

// ===== rtl/core/addressed_frame_checker_top.sv =====
// addressed_frame_checker_top: frame byte checker with apb local address register
// depends on afc_pkg
//
// usage
// the s_ channel carries one received frame word per handshake, s_frame_end on
// the last word of a frame. each word is checked in the cycle it is accepted
// and its results (a delayed payload word and, on the last word, a verdict
// word) go into a four entry result queue that drives the m_ channel.
// a result is written into the queue when its word is accepted and is offered on m_
// once it reaches the head of the queue. one input word per cycle while s_ready is
// high; a frame end word yields up to two results.
// s_ready is high while the result queue has room for two results; when the
// receiver stalls the queue fills and s_ready drops, nothing is lost.
// local_address sits at apb byte address 0, write it only while idle.
// reset (aresetn low, synchronous) clears the frame state, empties the queue
// and sets local_address to 0.
module addressed_frame_checker_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_payload_byte,
    output logic                          m_end_of_frame,
    output logic [2:0]                    m_verdict,
    output logic [15:0]                   m_source_address,
    output logic [7:0]                    m_frame_length
);
    import afc_pkg::*;

    logic [15:0] local_address_reg;

    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        start_ok_reg, start_ok_next;
    logic [15:0] sender_reg, sender_next;
    logic [7:0]  dest_high_reg, dest_high_next;
    logic        dest_match_reg, dest_match_next;

    afc_result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;

    logic        s_accept, m_accept, cfg_write;
    logic        kept, emit_pay;
    logic [7:0]  upd_count, upd_sum, upd_held, chk_expect;
    logic        upd_start_ok, upd_dest_match;
    logic [15:0] upd_sender;
    logic [7:0]  upd_dest_high;
    logic [2:0]  verdict;
    afc_result_t pay_res, verd_res;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [QCNT_W-1:0] push_n;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_LOCAL_ADDRESS);
    assign prdata    = (paddr == ADDR_LOCAL_ADDRESS) ? {16'd0, local_address_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_address_reg <= 16'd0;
        end else if (cfg_write) begin
            local_address_reg <= pwdata[15:0];
        end
    end

    assign s_ready  = (count_reg <= QUEUE_PUSH_LEVEL);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign m_accept = m_valid && m_ready;

    // frame check of the accepted word
    always_comb begin
        kept           = (byte_count_reg < MAX_FRAME_BYTES);
        emit_pay       = kept && (byte_count_reg >= MIN_FRAME_BYTES)
                         && start_ok_reg && dest_match_reg;
        upd_count      = byte_count_reg;
        upd_sum        = running_sum_reg;
        upd_held       = held_byte_reg;
        upd_start_ok   = start_ok_reg;
        upd_sender     = sender_reg;
        upd_dest_high  = dest_high_reg;
        upd_dest_match = dest_match_reg;
        if (kept) begin
            case (byte_count_reg)
                8'd0: begin
                    upd_start_ok = (s_rx_byte == START_BYTE);
                end
                8'd1: begin
                    upd_sender = {s_rx_byte, sender_reg[7:0]};
                end
                8'd2: begin
                    upd_sender = {sender_reg[15:8], s_rx_byte};
                end
                8'd3: begin
                    upd_dest_high = s_rx_byte;
                end
                8'd4: begin
                    upd_dest_match = ({dest_high_reg, s_rx_byte} == local_address_reg);
                end
                default: begin
                end
            endcase
            upd_sum   = running_sum_reg + held_byte_reg;
            upd_held  = s_rx_byte;
            upd_count = byte_count_reg + 8'd1;
        end

        chk_expect = 8'd0 - upd_sum;
        if (upd_count < MIN_FRAME_BYTES) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (!upd_start_ok) begin
            verdict = VERDICT_BAD_START;
        end else if (!upd_dest_match) begin
            verdict = VERDICT_ADDR_MISMATCH;
        end else if (chk_expect != upd_held) begin
            verdict = VERDICT_BAD_CHECKSUM;
        end else begin
            verdict = VERDICT_ACCEPTED;
        end

        pay_res  = '{payload_byte: held_byte_reg, end_of_frame: 1'b0,
                     verdict: VERDICT_ACCEPTED, source_address: 16'd0, frame_length: 8'd0};
        verd_res = '{payload_byte: 8'd0, end_of_frame: 1'b1, verdict: verdict,
                     source_address: upd_sender, frame_length: upd_count};

        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        held_byte_next   = held_byte_reg;
        start_ok_next    = start_ok_reg;
        sender_next      = sender_reg;
        dest_high_next   = dest_high_reg;
        dest_match_next  = dest_match_reg;
        if (s_accept) begin
            if (s_frame_end) begin
                byte_count_next  = 8'd0;
                running_sum_next = 8'd0;
                held_byte_next   = 8'd0;
                start_ok_next    = 1'b0;
                sender_next      = 16'd0;
                dest_high_next   = 8'd0;
                dest_match_next  = 1'b0;
            end else begin
                byte_count_next  = upd_count;
                running_sum_next = upd_sum;
                held_byte_next   = upd_held;
                start_ok_next    = upd_start_ok;
                sender_next      = upd_sender;
                dest_high_next   = upd_dest_high;
                dest_match_next  = upd_dest_match;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            held_byte_reg   <= 8'd0;
            start_ok_reg    <= 1'b0;
            sender_reg      <= 16'd0;
            dest_high_reg   <= 8'd0;
            dest_match_reg  <= 1'b0;
        end else begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            held_byte_reg   <= held_byte_next;
            start_ok_reg    <= start_ok_next;
            sender_reg      <= sender_next;
            dest_high_reg   <= dest_high_next;
            dest_match_reg  <= dest_match_next;
        end
    end

    // result queue
    assign wr_ptr_plus1 = wr_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1};

    always_comb begin
        push_n = '0;
        if (s_accept) begin
            push_n = {{(QCNT_W-1){1'b0}}, emit_pay} + {{(QCNT_W-1){1'b0}}, s_frame_end};
        end
        wr_ptr_next = wr_ptr_reg + push_n[QPTR_W-1:0];
        rd_ptr_next = m_accept ? rd_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1} : rd_ptr_reg;
        count_next  = count_reg + push_n - {{(QCNT_W-1){1'b0}}, m_accept};
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (emit_pay) begin
                queue_reg[wr_ptr_reg] <= pay_res;
                if (s_frame_end) begin
                    queue_reg[wr_ptr_plus1] <= verd_res;
                end
            end else if (s_frame_end) begin
                queue_reg[wr_ptr_reg] <= verd_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign m_payload_byte   = queue_reg[rd_ptr_reg].payload_byte;
    assign m_end_of_frame   = queue_reg[rd_ptr_reg].end_of_frame;
    assign m_verdict        = queue_reg[rd_ptr_reg].verdict;
    assign m_source_address = queue_reg[rd_ptr_reg].source_address;
    assign m_frame_length   = queue_reg[rd_ptr_reg].frame_length;

    // checks
    a_queue_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_FULL_LEVEL)
        else $error("result queue overflow");

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= MAX_FRAME_BYTES)
        else $error("byte count beyond frame limit");

    a_frame_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_frame_end) |=> (byte_count_reg == 8'd0) && !start_ok_reg
                                      && !dest_match_reg)
        else $error("frame state not cleared after verdict");

    a_pay_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_of_frame) |-> (m_verdict == VERDICT_ACCEPTED)
                                         && (m_source_address == 16'd0)
                                         && (m_frame_length == 8'd0))
        else $error("payload word carries verdict fields");

    a_verdict_len : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_frame && (m_verdict != VERDICT_TOO_SHORT))
            |-> (m_frame_length >= MIN_FRAME_BYTES))
        else $error("long verdict on short frame");

endmodule

// ===== test/addressed_frame_checker_top_tb.sv =====
// addressed_frame_checker_top_tb: self-checking bench for the addressed frame checker
// writes local_address over apb, sends frame words with random gaps and result stalls,
// predicts every result word and compares it; depends on afc_pkg and the top module
module addressed_frame_checker_top_tb;
    import afc_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 300;
    localparam int MAX_REPORTS   = 10;

    localparam int POS_START   = 0;
    localparam int POS_SRC_HI  = 1;
    localparam int POS_SRC_LO  = 2;
    localparam int POS_DEST_HI = 3;
    localparam int POS_DEST_LO = 4;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_START,
        FRAME_BAD_DEST,
        FRAME_BAD_SUM,
        FRAME_SHORT,
        FRAME_NOISE
    } frame_kind_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [31:0]          pwdata      = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte   = '0;
    logic                 s_frame_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [7:0]           m_payload_byte;
    logic                 m_end_of_frame;
    logic [2:0]           m_verdict;
    logic [15:0]          m_source_address;
    logic [7:0]           m_frame_length;

    // predicted block state
    logic [15:0] node_address     = '0;
    logic [7:0]  frame_count      = '0;
    logic [7:0]  frame_sum        = '0;
    logic [7:0]  frame_held       = '0;
    logic        frame_start_ok   = 1'b0;
    logic [15:0] frame_sender     = '0;
    logic [7:0]  frame_dest_hi    = '0;
    logic        frame_dest_match = 1'b0;

    afc_result_t owed_results[$];
    logic [7:0]  frame_buf[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;

    addressed_frame_checker_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_frame_end      (s_frame_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_end_of_frame   (m_end_of_frame),
        .m_verdict        (m_verdict),
        .m_source_address (m_source_address),
        .m_frame_length   (m_frame_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic advance_frame(input logic [7:0] b, input logic fe);
        afc_result_t r;
        logic [7:0]  want_sum;
        if (frame_count < MAX_FRAME_BYTES) begin
            if (frame_count >= MIN_FRAME_BYTES && frame_start_ok && frame_dest_match) begin
                r = '0;
                r.payload_byte = frame_held;
                owed_results.push_back(r);
            end
            case (int'(frame_count))
                POS_START:   frame_start_ok = (b == START_BYTE);
                POS_SRC_HI:  frame_sender[15:8] = b;
                POS_SRC_LO:  frame_sender[7:0] = b;
                POS_DEST_HI: frame_dest_hi = b;
                POS_DEST_LO: frame_dest_match = ({frame_dest_hi, b} == node_address);
                default: ;
            endcase
            frame_sum   = frame_sum + frame_held;
            frame_held  = b;
            frame_count = frame_count + 8'd1;
        end
        if (fe) begin
            r = '0;
            r.end_of_frame   = 1'b1;
            r.source_address = frame_sender;
            r.frame_length   = frame_count;
            want_sum = 8'd0 - frame_sum;
            if (frame_count < MIN_FRAME_BYTES) begin
                r.verdict = VERDICT_TOO_SHORT;
            end else if (!frame_start_ok) begin
                r.verdict = VERDICT_BAD_START;
            end else if (!frame_dest_match) begin
                r.verdict = VERDICT_ADDR_MISMATCH;
            end else if (want_sum != frame_held) begin
                r.verdict = VERDICT_BAD_CHECKSUM;
            end else begin
                r.verdict = VERDICT_ACCEPTED;
            end
            owed_results.push_back(r);
            frame_count      = '0;
            frame_sum        = '0;
            frame_held       = '0;
            frame_start_ok   = 1'b0;
            frame_sender     = '0;
            frame_dest_hi    = '0;
            frame_dest_match = 1'b0;
        end
    endtask

    // result side: random stall before each word
    always begin : rx_side
        int gap;
        gap = rx_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            m_ready <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!(m_valid && m_ready));
    end

    always @(posedge aclk) begin : result_check
        afc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                note_failure($sformatf(
                    "unexpected result word: pay %02h eof %0d verdict %0d src %04h len %0d",
                    m_payload_byte, m_end_of_frame, m_verdict, m_source_address,
                    m_frame_length));
            end else begin
                want = owed_results.pop_front();
                if (m_payload_byte !== want.payload_byte ||
                    m_end_of_frame !== want.end_of_frame ||
                    m_verdict !== want.verdict ||
                    m_source_address !== want.source_address ||
                    m_frame_length !== want.frame_length) begin
                    note_failure($sformatf({
                        "result mismatch: expected pay %02h eof %0d verdict %0d src %04h",
                        " len %0d, got pay %02h eof %0d verdict %0d src %04h len %0d"},
                        want.payload_byte, want.end_of_frame, want.verdict,
                        want.source_address, want.frame_length,
                        m_payload_byte, m_end_of_frame, m_verdict, m_source_address,
                        m_frame_length));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic fe);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_rx_byte   <= b;
        s_frame_end <= fe;
        do @(posedge aclk); while (!(s_valid && s_ready));
        advance_frame(b, fe);
    endtask

    task automatic send_frame_span(input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            send_word(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic send_frame();
        send_frame_span(0, frame_buf.size());
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (a == ADDR_LOCAL_ADDRESS) begin
            node_address = d[15:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_local_address();
        logic [31:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LOCAL_ADDRESS;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== {16'h0000, node_address}) begin
            note_failure($sformatf("local_address read back %08h, expected %08h",
                                   data, {16'h0000, node_address}));
        end
    endtask

    task automatic set_local_address(input logic [31:0] value);
        apb_write(ADDR_LOCAL_ADDRESS, value);
        check_local_address();
    endtask

    task automatic seal_frame(input bit corrupt);
        logic [7:0] sum;
        sum = '0;
        foreach (frame_buf[i]) sum = sum + frame_buf[i];
        sum = 8'd0 - sum;
        if (corrupt) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        frame_buf.push_back(sum);
    endtask

    task automatic build_frame(input frame_kind_t kind, input int len);
        logic [15:0] src;
        logic [15:0] dest;
        logic [7:0]  first;
        int          keep;
        frame_buf.delete();
        if (kind == FRAME_NOISE) begin
            repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
        end else begin
            src  = 16'($urandom);
            dest = node_address;
            if (kind == FRAME_BAD_DEST) begin
                dest = node_address ^ 16'($urandom_range(1, 65535));
            end
            first = START_BYTE;
            if (kind == FRAME_BAD_START) begin
                first = 8'($urandom);
                if (first == START_BYTE) begin
                    first = ~first;
                end
            end
            frame_buf.push_back(first);
            frame_buf.push_back(src[15:8]);
            frame_buf.push_back(src[7:0]);
            frame_buf.push_back(dest[15:8]);
            frame_buf.push_back(dest[7:0]);
            repeat (len) frame_buf.push_back(8'($urandom));
            seal_frame(kind == FRAME_BAD_SUM);
            if (kind == FRAME_SHORT) begin
                keep = $urandom_range(1, 5);
                while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            end
        end
    endtask

    task automatic test_reset_address();
        check_local_address();
        frame_buf = '{START_BYTE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
        seal_frame(1'b0);
        send_frame();
    endtask

    task automatic test_short_frames();
        frame_buf = '{8'h00};
        send_frame();
        frame_buf = '{START_BYTE, 8'h12};
        send_frame();
    endtask

    task automatic test_verdict_priority();
        wait_drained();
        set_local_address(32'hFFFF_FFFF);
        frame_buf = '{8'h55, 8'h01, 8'h02, 8'h00, 8'h00};
        seal_frame(1'b1);
        send_frame();
        frame_buf = '{START_BYTE, 8'h03, 8'h04, 8'h00, 8'h00};
        seal_frame(1'b1);
        send_frame();
        frame_buf = '{START_BYTE, 8'h80, 8'h7F, 8'hFF, 8'hFF};
        seal_frame(1'b1);
        send_frame();
    endtask

    task automatic test_address_change_mid_frame();
        // new address before the low destination word counts
        frame_buf = '{START_BYTE, 8'h5A, 8'hC3, 8'h12, 8'h34, 8'h99};
        seal_frame(1'b0);
        send_frame_span(0, POS_DEST_LO);
        wait_drained();
        set_local_address(32'h0000_1234);
        send_frame_span(POS_DEST_LO, frame_buf.size());
        // change after it does not
        frame_buf = '{START_BYTE, 8'h00, 8'h01, 8'h12, 8'h34};
        seal_frame(1'b0);
        send_frame_span(0, POS_DEST_LO + 1);
        wait_drained();
        set_local_address(32'h0000_0000);
        send_frame_span(POS_DEST_LO + 1, frame_buf.size());
    endtask

    task automatic test_length_limit();
        wait_drained();
        set_local_address($urandom);
        build_frame(FRAME_GOOD, int'(MAX_FRAME_BYTES) - 6);
        repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom));
        send_frame();
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          nframe;
        int          pick;
        int          len;
        frame_kind_t kind;
        sent   = 0;
        nframe = 0;
        while (sent < RANDOM_WORDS) begin
            if (nframe % 10 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
                wait_drained();
                case ($urandom_range(0, 3))
                    0:       set_local_address(32'h0000_0000);
                    1:       set_local_address(32'h0000_FFFF);
                    default: set_local_address($urandom);
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                kind = FRAME_GOOD;
            end else if (pick < 63) begin
                kind = FRAME_BAD_START;
            end else if (pick < 71) begin
                kind = FRAME_BAD_DEST;
            end else if (pick < 79) begin
                kind = FRAME_BAD_SUM;
            end else if (pick < 87) begin
                kind = FRAME_SHORT;
            end else begin
                kind = FRAME_NOISE;
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            build_frame(kind, len);
            send_frame();
            sent += frame_buf.size();
            nframe++;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin : main_sequence
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_address();
        test_short_frames();
        test_verdict_priority();
        test_address_change_mid_frame();
        test_length_limit();
        test_random_traffic();
        wait_drained();
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/afc_pkg.sv
rtl/core/addressed_frame_checker_top.sv
test/addressed_frame_checker_top_tb.sv
